### hdl/windowed_throughput_meter_assert.svh
// Assertion macros shared by the throughput meter RTL.
`ifndef WINDOWED_THROUGHPUT_METER_ASSERT_SVH
`define WINDOWED_THROUGHPUT_METER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WTM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define WTM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/wtm_pkg.sv
// Constants for the windowed throughput meter.
`timescale 1ns / 1ps

package wtm_pkg;

    localparam int SAMPLE_W           = 32;
    localparam int INTERVAL_W         = 16;
    localparam int RATE_W             = 46;
    localparam int SCALED_W           = 20;
    localparam int UNIT_W             = 3;
    localparam int UNIT_SHIFT         = 10;
    localparam int RING_SLOTS_DEFAULT = 16;
    localparam int TOP_UNIT_DEFAULT   = 4;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1000;

endpackage

### hdl/windowed_throughput_meter.sv
// Sliding-window average throughput meter with a serial restoring divider.
`timescale 1ns / 1ps
`include "windowed_throughput_meter_assert.svh"

// Channel   Direction  Payload (lowest bits first)
// s_        in         sample_bytes[31:0]
// m_        out        window_count, rate_bytes_per_s[45:0], scaled_rate[19:0], unit_index[2:0]
// cfg_      in         interval_ms[15:0]
//
// From acceptance an item passes ADJ, MUL1, MUL2, the divider (DIV), the unit scaling
// (SCALE) and DONE before its result is registered on m_; s_tready returns only once
// the block is back in IDLE, so no new item is taken while one is in flight. The
// restoring divider takes one quotient bit a cycle.
// Reset (aresetn low, synchronous) empties the window and sets interval_ms to 1000.
// The next item is taken while a result still waits on m_; the finished result
// then holds inside the block until the output register frees up.
module windowed_throughput_meter #(
    parameter int RING_SLOTS = wtm_pkg::RING_SLOTS_DEFAULT,
    parameter int TOP_UNIT   = wtm_pkg::TOP_UNIT_DEFAULT,
    parameter int CNT_W      = $clog2(RING_SLOTS),
    parameter int TDATA_W    = ((CNT_W + wtm_pkg::RATE_W + wtm_pkg::SCALED_W
                                 + wtm_pkg::UNIT_W + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // sample_bytes[31:0]
    input  logic [wtm_pkg::SAMPLE_W-1:0]    s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // window_count, rate_bytes_per_s, scaled_rate, unit_index, zero fill
    output logic [TDATA_W-1:0]              m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // interval_ms[15:0]
    input  logic [wtm_pkg::INTERVAL_W-1:0]  cfg_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready
);
    import wtm_pkg::*;

    localparam int PTR_W  = $clog2(RING_SLOTS);
    localparam int SUM_W  = SAMPLE_W + $clog2(RING_SLOTS);
    localparam int NUM_W  = SUM_W + 10;                 // sum * 1000
    localparam int QW     = (SUM_W + 20 > RATE_W + UNIT_SHIFT) ? SUM_W + 20
                                                           : RATE_W + UNIT_SHIFT;
    localparam int DEN_W  = CNT_W + INTERVAL_W;
    localparam int ITER_W = $clog2(QW + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ADJ   = 3'd1;
    localparam logic [2:0] ST_MUL1  = 3'd2;
    localparam logic [2:0] ST_MUL2  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_SCALE = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    // Sample ring: written at the newest slot, read at the oldest slot.
    logic [SAMPLE_W-1:0] ring_mem [RING_SLOTS];
    logic [SAMPLE_W-1:0] oldest_data_reg;

    logic [2:0]            state_reg, state_next;
    logic [PTR_W-1:0]      newest_reg, newest_next;
    logic [PTR_W-1:0]      oldest_reg, oldest_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [INTERVAL_W-1:0] interval_reg, interval_next;
    logic                  full_reg, full_next;
    logic [NUM_W-1:0]      num_reg, num_next;
    logic [DEN_W-1:0]      den_reg, den_next;
    logic [DEN_W:0]        rem_reg, rem_next;
    logic [QW-1:0]         quo_reg, quo_next;
    logic [QW-1:0]         sc_reg, sc_next;
    logic [ITER_W-1:0]     iter_reg, iter_next;
    logic [UNIT_W-1:0]     unit_reg, unit_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0]    m_tdata_reg, m_tdata_next;

    logic                  s_accept;
    logic                  out_free;
    logic [INTERVAL_W-1:0] iv_eff;
    logic [DEN_W:0]        rem_shift;
    logic                  rem_fits;
    logic [RATE_W-1:0]     rate_val;
    logic [SCALED_W-1:0]   scaled_val;
    logic                  sc_over;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Zero interval counts as one millisecond.
    assign iv_eff = (interval_reg == '0) ? INTERVAL_W'(1) : interval_reg;

    // Restoring divider step: shift in the next dividend bit, try the subtract.
    assign rem_shift = {rem_reg[DEN_W-1:0], quo_reg[QW-1]};
    assign rem_fits  = (rem_shift >= {1'b0, den_reg});

    // Rate is the quotient without its ten fraction bits, cut to 46 bits.
    assign rate_val   = quo_reg[UNIT_SHIFT +: RATE_W];
    assign sc_over    = (sc_reg[QW-1:SCALED_W] != '0);
    assign scaled_val = sc_over ? '1 : sc_reg[SCALED_W-1:0];

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ring_mem[newest_reg] <= s_tdata;
        end
        oldest_data_reg <= ring_mem[oldest_reg];
    end

    always_comb begin
        state_next    = state_reg;
        newest_next   = newest_reg;
        oldest_next   = oldest_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        interval_next = interval_reg;
        full_next     = full_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        sc_next       = sc_reg;
        iter_next     = iter_reg;
        unit_next     = unit_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (cfg_valid && cfg_ready) begin
            interval_next = cfg_data;
        end
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    sum_next    = sum_reg + SUM_W'(s_tdata);
                    newest_next = (newest_reg == PTR_W'(RING_SLOTS - 1)) ? '0
                                                                         : newest_reg + 1'b1;
                    full_next   = (newest_next == oldest_reg);
                    state_next  = ST_ADJ;
                end
            end
            ST_ADJ: begin
                // Drop the oldest sample once the ring wraps, else grow the window.
                if (full_reg) begin
                    sum_next    = sum_reg - SUM_W'(oldest_data_reg);
                    oldest_next = (oldest_reg == PTR_W'(RING_SLOTS - 1)) ? '0
                                                                         : oldest_reg + 1'b1;
                end else begin
                    count_next = count_reg + 1'b1;
                end
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                // sum * 1000 = sum*1024 - sum*16 - sum*8
                num_next   = {sum_reg, 10'b0} - NUM_W'({sum_reg, 4'b0});
                den_next   = DEN_W'(count_reg) * DEN_W'(iv_eff);
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                num_next   = num_reg - NUM_W'({sum_reg, 3'b0});
                state_next = ST_DIV;
                rem_next   = '0;
                iter_next  = '0;
                // Dividend is sum * 1000 * 1024.
                quo_next   = QW'({num_next, 10'b0});
            end
            ST_DIV: begin
                rem_next  = rem_fits ? rem_shift - {1'b0, den_reg} : rem_shift;
                quo_next  = {quo_reg[QW-2:0], rem_fits};
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(QW - 1)) begin
                    sc_next    = quo_next;
                    unit_next  = '0;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                // Advance one unit of 1024 a cycle until it fits or the top unit.
                if (unit_reg < UNIT_W'(TOP_UNIT) && sc_over) begin
                    sc_next   = sc_reg >> UNIT_SHIFT;
                    unit_next = unit_reg + 1'b1;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tdata_next  = TDATA_W'({unit_reg, scaled_val, rate_val, count_reg});
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            newest_reg   <= '0;
            oldest_reg   <= '0;
            sum_reg      <= '0;
            count_reg    <= '0;
            interval_reg <= INTERVAL_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            newest_reg   <= newest_next;
            oldest_reg   <= oldest_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            interval_reg <= interval_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        full_reg    <= full_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        sc_reg      <= sc_next;
        iter_reg    <= iter_next;
        unit_reg    <= unit_next;
        m_tdata_reg <= m_tdata_next;
    end

    `WTM_ASSERT_NOW(a_rem_below_den, state_reg == ST_DIV, rem_reg < {1'b0, den_reg}, "divider remainder out of range")
    `WTM_ASSERT_NEXT(a_count_grows, state_reg == ST_ADJ && !full_reg, count_reg == $past(count_reg) + 1'b1, "window count did not grow")
    `WTM_ASSERT_NEXT(a_oldest_moves, state_reg == ST_ADJ && full_reg, oldest_reg != $past(oldest_reg), "oldest slot not dropped")
    `WTM_ASSERT_NOW(a_unit_fits, state_reg == ST_DONE && unit_reg < UNIT_W'(TOP_UNIT), !sc_over, "scaling stopped early")
    `WTM_ASSERT_NOW(a_count_nonzero, m_tvalid_reg, m_tdata_reg[CNT_W-1:0] != '0, "result with empty window")

endmodule

### tb/wtm_rate_checker.sv
// Checker that tracks the sample window and compares every rate report of the meter.
`timescale 1ns / 1ps

module wtm_rate_checker #(
    parameter int RESULT_W = 80
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [wtm_pkg::SAMPLE_W-1:0]   s_tdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [RESULT_W-1:0]            m_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [wtm_pkg::INTERVAL_W-1:0] cfg_data,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    output int                             mismatches,
    output int                             reports_due,
    output int                             reports_seen,
    output int                             window_drops,
    output logic [wtm_pkg::TOP_UNIT_DEFAULT:0] units_seen
);
    import wtm_pkg::*;

    localparam int SLOTS   = RING_SLOTS_DEFAULT;
    localparam int COUNT_W = $clog2(SLOTS);
    // 1000 ms per second, carrying 10 fraction bits for the scaled output
    localparam logic [63:0] MS_PER_S_FRAC = 64'd1024000;
    localparam logic [63:0] UNIT_STEP     = 64'd1 << UNIT_SHIFT;

    // Packed with the window count in the lowest bits, as on m_tdata.
    typedef struct packed {
        logic [UNIT_W-1:0]   unit;
        logic [SCALED_W-1:0] scaled;
        logic [RATE_W-1:0]   rate;
        logic [COUNT_W-1:0]  window_count;
    } rate_report_t;

    logic [SAMPLE_W-1:0]     ring [SLOTS];
    int                      oldest = 0;
    int                      newest = 0;
    int                      held = 0;
    logic [63:0]             sum_bytes = '0;
    logic [INTERVAL_W-1:0]   interval_ms = INTERVAL_RESET;
    rate_report_t            rate_due_q [$];
    int                      errs = 0;
    int                      seen = 0;
    int                      drops = 0;
    logic [TOP_UNIT_DEFAULT:0] units = '0;

    // Advance the window by one sample and queue the report it must produce.
    task automatic account_sample(input logic [SAMPLE_W-1:0] smp);
        logic [63:0]  den;
        logic [63:0]  q;
        logic [63:0]  rate;
        logic [63:0]  sh;
        int           unit;
        rate_report_t r;
        ring[newest] = smp;
        sum_bytes    = sum_bytes + smp;
        newest       = (newest + 1) % SLOTS;
        if (newest == oldest) begin
            sum_bytes = sum_bytes - ring[oldest];
            oldest    = (oldest + 1) % SLOTS;
            drops++;
        end else begin
            held++;
        end
        den  = 64'(held) * ((interval_ms == '0) ? 64'd1 : 64'(interval_ms));
        q    = (sum_bytes * MS_PER_S_FRAC) / den;
        rate = q >> UNIT_SHIFT;
        unit = 0;
        while (unit < TOP_UNIT_DEFAULT && (rate >> (UNIT_SHIFT * unit)) >= UNIT_STEP)
            unit++;
        sh = q >> (UNIT_SHIFT * unit);
        r.window_count = COUNT_W'(held);
        r.rate         = rate[RATE_W-1:0];
        r.scaled       = (sh > 64'({SCALED_W{1'b1}})) ? '1 : sh[SCALED_W-1:0];
        r.unit         = UNIT_W'(unit);
        rate_due_q.push_back(r);
    endtask

    always @(posedge aclk) begin
        rate_report_t got;
        rate_report_t want;
        if (!aresetn) begin
            oldest      = 0;
            newest      = 0;
            held        = 0;
            sum_bytes   = '0;
            interval_ms = INTERVAL_RESET;
            rate_due_q.delete();
        end else begin
            // retire the oldest report before queuing a new one
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(rate_report_t)-1:0];
                if (rate_due_q.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("checker: unexpected report %h at %0t ns", m_tdata, $time);
                end else begin
                    want = rate_due_q.pop_front();
                    seen++;
                    units[want.unit] = 1'b1;
                    if (got.window_count !== want.window_count || got.rate !== want.rate ||
                        got.scaled !== want.scaled || got.unit !== want.unit) begin
                        errs++;
                        if (errs <= 10)
                            $display({"checker: report %0d at %0t ns: count %0d/%0d ",
                                      "rate %0d/%0d scaled %h/%h unit %0d/%0d (exp/act)"},
                                     seen, $time, want.window_count, got.window_count,
                                     want.rate, got.rate, want.scaled, got.scaled,
                                     want.unit, got.unit);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                interval_ms = cfg_data;
            if (s_tvalid && s_tready)
                account_sample(s_tdata);
        end
        mismatches   <= errs;
        reports_due  <= rate_due_q.size();
        reports_seen <= seen;
        window_drops <= drops;
        units_seen   <= units;
    end

endmodule

### tb/tb_windowed_throughput_meter.sv
// Testbench top: drives samples and interval writes into the throughput meter.
`timescale 1ns / 1ps

module tb_windowed_throughput_meter;
    import wtm_pkg::*;

    localparam int COUNT_W        = $clog2(RING_SLOTS_DEFAULT);
    localparam int RESULT_W       = ((COUNT_W + RATE_W + SCALED_W + UNIT_W + 7) / 8) * 8;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 175;
    localparam int PRESSURE_PHASE = 3;
    localparam int HOLD_CYCLES    = 1500;  // long enough for the block to fill up and hold the sender off
    localparam int SETTLE_CYCLES  = 100;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic [SAMPLE_W-1:0]   s_tdata   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [RESULT_W-1:0]   m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [INTERVAL_W-1:0] cfg_data  = '0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;

    int                    mismatches;
    int                    reports_due;
    int                    reports_seen;
    int                    window_drops;
    logic [TOP_UNIT_DEFAULT:0] units_seen;

    int                    samples_sent    = 0;
    int                    interval_writes = 0;
    int                    stall_pct       = 0;  // chance that the receiver starts a stall
    int                    stall_left      = 0;
    int                    gap_max         = 0;  // longest sender gap; zero means back to back
    logic                  hold_off        = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    windowed_throughput_meter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    wtm_rate_checker #(.RESULT_W(RESULT_W)) rate_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tdata      (s_tdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .m_tdata      (m_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .cfg_data     (cfg_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .mismatches   (mismatches),
        .reports_due  (reports_due),
        .reports_seen (reports_seen),
        .window_drops (window_drops),
        .units_seen   (units_seen)
    );

    // Receiver: stalls of random length started at random; a hold-off overrides all.
    always @(negedge aclk) begin
        if (hold_off) begin
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if ($urandom_range(99) < stall_pct) begin
            stall_left <= $urandom_range(1, 15);
            m_tready   <= 1'b0;
        end else begin
            m_tready   <= 1'b1;
        end
    end

    // Offer one sample and hold it until the meter takes it.
    task automatic push_sample(input logic [SAMPLE_W-1:0] value);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
    endtask

    // Drop valid for a number of cycles, with junk on the data lines.
    task automatic rest_sender(input int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
        end
    endtask

    // Stop offering and wait until every queued report has come out.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (reports_due != 0) @(negedge aclk);
    endtask

    // Write the interval only once the meter is idle.
    task automatic write_interval(input logic [INTERVAL_W-1:0] value);
        settle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        interval_writes++;
    endtask

    // Mostly samples of one magnitude so the average settles inside a unit.
    function automatic logic [SAMPLE_W-1:0] draw_sample(input int mag);
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom >> $urandom_range(31);
            default: return $urandom >> mag;
        endcase
    endfunction

    function automatic logic [INTERVAL_W-1:0] phase_interval(input int p);
        case (p)
            0:       return 16'd1;
            1:       return '1;
            2:       return '0;
            3:       return INTERVAL_RESET;
            4:       return 16'($urandom_range(2, 50));
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    initial begin
        int burst;
        int mag;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset interval, field extremes, then a zero interval
        // with the window overfilled to reach the top unit.
        push_sample('0);
        push_sample('1);
        push_sample(32'd1);
        push_sample(32'd1023);
        push_sample(32'd1024);
        write_interval('0);
        repeat (12) push_sample('1);
        // longest interval with alternating bit patterns
        write_interval('1);
        push_sample(32'hAAAA_AAAA);
        push_sample(32'h5555_5555);
        push_sample(32'd1);
        write_interval(16'd1);
        push_sample(32'h8000_0000);
        push_sample('0);
        push_sample(32'd7);

        // Random phases, each under its own interval and idling shape.
        for (int p = 0; p < PHASES; p++) begin
            stall_pct = (p % 4 == 1) ? 0 : $urandom_range(10, 60);
            gap_max   = (p % 3 == 0) ? 0 : $urandom_range(20, 120);
            mag       = $urandom_range(31);
            write_interval(phase_interval(p));
            if (p == PRESSURE_PHASE) begin
                // hold the receiver off while samples keep coming
                fork
                    begin
                        @(posedge aclk);
                        hold_off = 1'b1;
                        repeat (HOLD_CYCLES) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            burst = $urandom_range(1, 8);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                push_sample(draw_sample(mag));
                burst--;
                if (burst == 0) begin
                    if (gap_max != 0)
                        rest_sender($urandom_range(1, gap_max));
                    burst = $urandom_range(1, 8);
                end
            end
        end

        // Drain, then leave time for any stray report to show up.
        settle();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        $display("Summary: %0d samples sent across %0d interval writes, %0d reports compared",
                 samples_sent, interval_writes, reports_seen);
        $display("Summary: units reached %b (lowest bit bytes/s), %0d full-window drops",
                 units_seen, window_drops);
        if (mismatches == 0 && reports_due == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #4_000_000;
        $display("watchdog: run did not complete, %0d reports still due", reports_due);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
